[hdl/fwlim_pkg.sv]
// Shared constants and types for the per-client fixed-window limiter.
package fwlim_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int KEY_W       = 32;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE         = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] REQ_LIMIT_INIT    = COUNT_W'(100);
    localparam logic [TIME_W-1:0]  WINDOW_TICKS_INIT = TIME_W'(60);

    // Register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] CFG_REQ_LIMIT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TICKS = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [COUNT_W-1:0] req_limit;
        logic [TIME_W-1:0]  window_ticks;
    } cfg_t;

    // Per-entry request to update
    typedef struct packed {
        logic go;    // a request is retiring this cycle
        logic hit;   // this entry is the selected match
        logic take;  // this entry is claimed by a new client
    } slot_cmd_t;

    // Per-entry lookup status against the current request
    typedef struct packed {
        logic               is_free;
        logic               match;
        logic               in_win;
        logic [COUNT_W-1:0] count_inc;
    } slot_stat_t;

endpackage

[hdl/fwlim_cfg.sv]
// Configuration registers: max request count and window length.
module fwlim_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fwlim_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fwlim_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fwlim_pkg::cfg_t                     cfg
);

    logic [fwlim_pkg::COUNT_W-1:0] req_limit_reg;
    logic [fwlim_pkg::TIME_W-1:0]  window_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_limit_reg    <= fwlim_pkg::REQ_LIMIT_INIT;
            window_ticks_reg <= fwlim_pkg::WINDOW_TICKS_INIT;
        end else if (cfg_valid) begin
            case (cfg_index)
                fwlim_pkg::CFG_REQ_LIMIT: begin
                    req_limit_reg <= cfg_data[fwlim_pkg::COUNT_W-1:0];
                end
                fwlim_pkg::CFG_WINDOW_TICKS: begin
                    window_ticks_reg <= cfg_data[fwlim_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.req_limit    = req_limit_reg;
    assign cfg.window_ticks = window_ticks_reg;

endmodule

[hdl/fwlim_slot.sv]
// One client table entry: storage, age/key compare and update.
module fwlim_slot (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fwlim_pkg::slot_cmd_t            cmd,
    input  logic [fwlim_pkg::KEY_W-1:0]     addr,
    input  logic [fwlim_pkg::TIME_W-1:0]    now,
    input  logic [fwlim_pkg::TIME_W-1:0]    window,
    output fwlim_pkg::slot_stat_t           stat
);

    logic                           valid_reg;
    logic [fwlim_pkg::KEY_W-1:0]    key_reg;
    logic [fwlim_pkg::COUNT_W-1:0]  count_reg;
    logic [fwlim_pkg::TIME_W-1:0]   start_reg;

    logic [fwlim_pkg::TIME_W-1:0]   age;
    logic                           stale;
    logic                           live;
    logic                           restart;

    // age wraps modulo 2^32
    assign age   = now - start_reg;
    assign stale = valid_reg && (age > window);
    assign live  = valid_reg && !stale;

    assign stat.is_free   = !live;
    assign stat.match     = live && (key_reg == addr);
    assign stat.in_win    = age < window;
    assign stat.count_inc = (count_reg == fwlim_pkg::COUNT_MAX) ? count_reg
                          : fwlim_pkg::COUNT_W'(count_reg + fwlim_pkg::COUNT_ONE);

    // hit at exactly the window age reopens the window
    assign restart = cmd.take || (cmd.hit && !stat.in_win);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.go) begin
            if (cmd.take) begin
                valid_reg <= 1'b1;
            end else if (stale) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.go) begin
            if (cmd.take) begin
                key_reg <= addr;
            end
            if (restart) begin
                count_reg <= fwlim_pkg::COUNT_ONE;
                start_reg <= now;
            end else if (cmd.hit) begin
                count_reg <= stat.count_inc;
            end
        end
    end

endmodule

[hdl/per_client_fixed_window_limiter_unit.sv]
// Per-client fixed-window rate limiter, top level.
//
// Input channel s_*: one word per request, client address and timestamp.
// Result channel m_*: one word per request, in order: allowed, the client's
// count after the request (0 when untracked) and a table-full flag.
// Config channel cfg_*: index 0 writes the request limit, index 1 window_ticks;
// other indexes are dropped. cfg_ready is always high; write only when idle.
//
// A request accepted into the input register is looked up from there; its
// result is written to the result register when it advances, raising m_valid.
// Throughput: one request per cycle while m_ready keeps the result register
// draining. The entry table is a row of registers, each compared in parallel,
// so every request sees the updates of the one before it with no gap.
// Stall: the input register and the result register hold one word each;
// when m_ready is low and both are full, s_ready drops. Nothing is lost.
// Reset: all entries are freed, the request limit returns to 100 and
// window_ticks to 60; both channels come up empty.
module per_client_fixed_window_limiter_unit #(
    parameter int TABLE_ENTRIES = fwlim_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fwlim_pkg::KEY_W-1:0]         s_client_addr,
    input  logic [fwlim_pkg::TIME_W-1:0]        s_now_time,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_allowed,
    output logic [fwlim_pkg::COUNT_W-1:0]       m_count_now,
    output logic                                m_table_full,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fwlim_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fwlim_pkg::CFG_DATA_W-1:0]    cfg_data
);

    fwlim_pkg::cfg_t cfg;

    logic                           in_valid_reg;
    logic [fwlim_pkg::KEY_W-1:0]    addr_reg;
    logic [fwlim_pkg::TIME_W-1:0]   now_reg;

    logic                           out_valid_reg;
    logic                           allowed_reg;
    logic [fwlim_pkg::COUNT_W-1:0]  count_reg;
    logic                           full_reg;

    logic                           advance;

    fwlim_pkg::slot_stat_t          stat [TABLE_ENTRIES];
    fwlim_pkg::slot_cmd_t           cmd  [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0]       match_vec;
    logic [TABLE_ENTRIES-1:0]       free_vec;
    logic [TABLE_ENTRIES-1:0]       hit_oh;
    logic [TABLE_ENTRIES-1:0]       take_oh;
    logic                           any_hit;
    logic                           any_free;
    logic [fwlim_pkg::COUNT_W-1:0]  hit_count;
    logic                           hit_in_win;

    logic                           allowed_next;
    logic [fwlim_pkg::COUNT_W-1:0]  count_next;
    logic                           full_next;

    fwlim_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            addr_reg <= s_client_addr;
            now_reg  <= s_now_time;
        end
    end

    generate
        for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_slot
            assign match_vec[i] = stat[i].match;
            assign free_vec[i]  = stat[i].is_free;
            assign cmd[i].go    = advance;
            assign cmd[i].hit   = hit_oh[i];
            assign cmd[i].take  = take_oh[i];

            fwlim_slot u_slot (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd[i]),
                .addr    (addr_reg),
                .now     (now_reg),
                .window  (cfg.window_ticks),
                .stat    (stat[i])
            );
        end
    endgenerate

    // lowest set bit wins
    assign hit_oh   = match_vec & (-match_vec);
    assign any_hit  = |match_vec;
    assign any_free = |free_vec;
    assign take_oh  = any_hit ? '0 : (free_vec & (-free_vec));

    always_comb begin
        hit_count  = '0;
        hit_in_win = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_count  = hit_count | ({fwlim_pkg::COUNT_W{hit_oh[i]}} & stat[i].count_inc);
            hit_in_win = hit_in_win | (hit_oh[i] & stat[i].in_win);
        end
    end

    always_comb begin
        allowed_next = 1'b1;
        full_next    = 1'b0;
        if (any_hit) begin
            if (hit_in_win) begin
                count_next   = hit_count;
                allowed_next = hit_count <= cfg.req_limit;
            end else begin
                count_next = fwlim_pkg::COUNT_ONE;
            end
        end else if (any_free) begin
            count_next = fwlim_pkg::COUNT_ONE;
        end else begin
            count_next = '0;
            full_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            allowed_reg <= allowed_next;
            count_reg   <= count_next;
            full_reg    <= full_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_allowed    = allowed_reg;
    assign m_count_now  = count_reg;
    assign m_table_full = full_reg;

    // A client matches at most one entry, and a new client never lands on a hit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_oh | take_oh))
    else $error("hit and take selects overlap or are not one-hot");

    // Untracked requests always pass with a zero count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && full_next) |=> (m_allowed && m_count_now == '0))
    else $error("table-full result must be allowed with zero count");

    // A denied request is always a tracked, counted one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !allowed_reg) |-> (count_reg != '0 && !full_reg))
    else $error("denied word without a tracked count");

    // A result word only appears when a request left the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
    else $error("result word without a pending request");

endmodule

[bench/fwlim_checker.sv]
`timescale 1ns / 1ps
// Checker for the fixed-window limiter: tracks the client table and compares every result word.
module fwlim_checker #(
    parameter int ENTRIES = fwlim_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [fwlim_pkg::KEY_W-1:0]       s_client_addr,
    input  logic [fwlim_pkg::TIME_W-1:0]      s_now_time,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_allowed,
    input  logic [fwlim_pkg::COUNT_W-1:0]     m_count_now,
    input  logic                              m_table_full,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [fwlim_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fwlim_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                fail_count,
    output int                                pending
);

    typedef struct packed {
        logic                          allowed;
        logic [fwlim_pkg::COUNT_W-1:0] count_now;
        logic                          table_full;
    } verdict_t;

    logic [fwlim_pkg::COUNT_W-1:0] max_req;
    logic [fwlim_pkg::TIME_W-1:0]  win;

    logic                          live      [ENTRIES];
    logic [fwlim_pkg::KEY_W-1:0]   key_tbl   [ENTRIES];
    logic [fwlim_pkg::COUNT_W-1:0] cnt_tbl   [ENTRIES];
    logic [fwlim_pkg::TIME_W-1:0]  start_tbl [ENTRIES];

    verdict_t verdict_q [$];

    task automatic predict_verdict(input logic [fwlim_pkg::KEY_W-1:0] addr,
                                   input logic [fwlim_pkg::TIME_W-1:0] now,
                                   output verdict_t v);
        int hit;
        int free_ix;
        logic [fwlim_pkg::TIME_W-1:0] age;
        v.allowed    = 1'b1;
        v.count_now  = '0;
        v.table_full = 1'b0;
        hit          = -1;
        free_ix      = -1;
        // expire stale entries before the lookup
        for (int i = 0; i < ENTRIES; i++) begin
            age = now - start_tbl[i];
            if (live[i] && age > win) live[i] = 1'b0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (live[i]) begin
                if (hit < 0 && key_tbl[i] == addr) hit = i;
            end else if (free_ix < 0) begin
                free_ix = i;
            end
        end
        if (hit >= 0) begin
            age = now - start_tbl[hit];
            if (age < win) begin
                if (cnt_tbl[hit] != fwlim_pkg::COUNT_MAX) begin
                    cnt_tbl[hit] = cnt_tbl[hit] + fwlim_pkg::COUNT_ONE;
                end
                v.allowed = (cnt_tbl[hit] <= max_req);
            end else begin
                // exactly one window old: reopen
                cnt_tbl[hit]   = fwlim_pkg::COUNT_ONE;
                start_tbl[hit] = now;
            end
            v.count_now = cnt_tbl[hit];
        end else if (free_ix >= 0) begin
            live[free_ix]      = 1'b1;
            key_tbl[free_ix]   = addr;
            cnt_tbl[free_ix]   = fwlim_pkg::COUNT_ONE;
            start_tbl[free_ix] = now;
            v.count_now        = fwlim_pkg::COUNT_ONE;
        end else begin
            v.table_full = 1'b1;
        end
    endtask

    // Sampled mid-cycle: values are stable and describe the transfer at the next rising edge.
    always @(negedge aclk) begin : watch
        verdict_t exp_v;
        if (!aresetn) begin
            max_req = fwlim_pkg::REQ_LIMIT_INIT;
            win     = fwlim_pkg::WINDOW_TICKS_INIT;
            for (int i = 0; i < ENTRIES; i++) live[i] = 1'b0;
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result word with no request outstanding");
                    fail_count++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (m_allowed !== exp_v.allowed) begin
                        $error("allowed: expected %0d, actual %0d", exp_v.allowed, m_allowed);
                        fail_count++;
                    end
                    if (m_count_now !== exp_v.count_now) begin
                        $error("count_now: expected %0d, actual %0d",
                               exp_v.count_now, m_count_now);
                        fail_count++;
                    end
                    if (m_table_full !== exp_v.table_full) begin
                        $error("table_full: expected %0d, actual %0d",
                               exp_v.table_full, m_table_full);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fwlim_pkg::CFG_REQ_LIMIT:    max_req = cfg_data[fwlim_pkg::COUNT_W-1:0];
                    fwlim_pkg::CFG_WINDOW_TICKS: win = cfg_data[fwlim_pkg::TIME_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_verdict(s_client_addr, s_now_time, exp_v);
                verdict_q.push_back(exp_v);
            end
        end
        pending = verdict_q.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the limiter testbench: clock, reset, request and config stimulus, and the verdict.
module testbench;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    localparam int LONG_HOLD    = 64;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [fwlim_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_IDX = fwlim_pkg::CFG_INDEX_W'(2);
    localparam logic [fwlim_pkg::CFG_INDEX_W-1:0] CFG_TOP_IDX    = '1;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [fwlim_pkg::KEY_W-1:0]       s_client_addr;
    logic [fwlim_pkg::TIME_W-1:0]      s_now_time;
    logic                              m_valid;
    logic                              m_ready;
    logic                              m_allowed;
    logic [fwlim_pkg::COUNT_W-1:0]     m_count_now;
    logic                              m_table_full;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [fwlim_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fwlim_pkg::CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;

    bit tx_idle_en;
    bit rx_idle_en;
    bit long_hold;

    logic [fwlim_pkg::TIME_W-1:0] tick;
    logic [fwlim_pkg::TIME_W-1:0] win_cur;

    per_client_fixed_window_limiter_unit #(
        .TABLE_ENTRIES(fwlim_pkg::TABLE_ENTRIES_DEF)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_client_addr(s_client_addr),
        .s_now_time   (s_now_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_allowed    (m_allowed),
        .m_count_now  (m_count_now),
        .m_table_full (m_table_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    fwlim_checker #(
        .ENTRIES(fwlim_pkg::TABLE_ENTRIES_DEF)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_client_addr(s_client_addr),
        .s_now_time   (s_now_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_allowed    (m_allowed),
        .m_count_now  (m_count_now),
        .m_table_full (m_table_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #HALF_PERIOD aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        bit held;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (long_hold && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_req(input logic [fwlim_pkg::KEY_W-1:0] addr,
                            input logic [fwlim_pkg::TIME_W-1:0] now);
        logic taken;
        s_valid       <= 1'b1;
        s_client_addr <= addr;
        s_now_time    <= now;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic idle_tx(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic await_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [fwlim_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fwlim_pkg::CFG_DATA_W-1:0] data);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
        cfg_valid <= 1'b0;
        if (idx == fwlim_pkg::CFG_WINDOW_TICKS) win_cur = data;
        @(posedge aclk);
    endtask

    // Requests from a small client pool on a mostly advancing clock, some noise mixed in.
    task automatic run_phase(input logic [fwlim_pkg::COUNT_W-1:0] max_req,
                             input logic [fwlim_pkg::TIME_W-1:0] win,
                             input int n_items, input int pool_sz);
        logic [fwlim_pkg::KEY_W-1:0] pool [32];
        logic [fwlim_pkg::KEY_W-1:0] addr;
        int r;
        write_reg(fwlim_pkg::CFG_REQ_LIMIT, fwlim_pkg::CFG_DATA_W'(max_req));
        write_reg(fwlim_pkg::CFG_WINDOW_TICKS, fwlim_pkg::CFG_DATA_W'(win));
        for (int k = 0; k < pool_sz; k++) pool[k] = $urandom();
        repeat (n_items) begin
            if (tx_idle_en && $urandom_range(0, 5) == 0) idle_tx($urandom_range(1, 6));
            r = $urandom_range(0, 99);
            if (r < 55)      tick = tick + $urandom_range(0, 1);
            else if (r < 80) tick = tick + $urandom_range(2, 6);
            else if (r < 88) tick = tick + win_cur;
            else if (r < 94) tick = tick - $urandom_range(1, 4);
            else if (r < 97) tick = tick + $urandom_range(20, 100);
            else             tick = $urandom();
            if ($urandom_range(0, 19) == 0) addr = $urandom();
            else addr = pool[$urandom_range(0, pool_sz - 1)];
            send_req(addr, tick);
        end
        await_drain();
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_client_addr = '0;
        s_now_time    = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        long_hold     = 1'b0;
        tick          = '0;
        win_cur       = fwlim_pkg::WINDOW_TICKS_INIT;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config first
        send_req('0, '0);
        send_req('0, '0);
        send_req('1, '1);
        send_req('0, fwlim_pkg::TIME_W'(60));   // key 0 was expired by the request above: new entry
        send_req('0, fwlim_pkg::TIME_W'(10));   // clock went backwards: entry expires
        for (int k = 1; k <= 16; k++) begin
            send_req(32'h8000_0000 | fwlim_pkg::KEY_W'(k), fwlim_pkg::TIME_W'(10));
        end
        await_drain();
        write_reg(fwlim_pkg::CFG_REQ_LIMIT, fwlim_pkg::CFG_DATA_W'(1));
        send_req('0, fwlim_pkg::TIME_W'(10));   // over the limit: denied
        await_drain();
        write_reg(fwlim_pkg::CFG_REQ_LIMIT, '0);
        write_reg(fwlim_pkg::CFG_WINDOW_TICKS, '1);
        send_req('0, fwlim_pkg::TIME_W'(11));   // zero limit denies every in-window hit
        await_drain();
        write_reg(fwlim_pkg::CFG_WINDOW_TICKS, '0);
        send_req('0, fwlim_pkg::TIME_W'(12));
        send_req('0, fwlim_pkg::TIME_W'(12));   // zero window: repeat at age zero reopens
        await_drain();
        write_reg(CFG_UNUSED_IDX, fwlim_pkg::CFG_DATA_W'(7));
        write_reg(CFG_TOP_IDX, '1);
        send_req('0, fwlim_pkg::TIME_W'(12));
        await_drain();
        tick = fwlim_pkg::TIME_W'(12);

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        long_hold  = 1'b1;
        run_phase(fwlim_pkg::COUNT_W'(100), fwlim_pkg::TIME_W'(60), 230, 20);
        run_phase(fwlim_pkg::COUNT_W'(1), fwlim_pkg::TIME_W'(1), 230, 6);
        run_phase('1, '1, 230, 24);
        run_phase(fwlim_pkg::COUNT_W'(3), fwlim_pkg::TIME_W'(20), 230, 12);
        run_phase('0, fwlim_pkg::TIME_W'(8), 230, 8);
        run_phase(fwlim_pkg::COUNT_W'(5), '0, 230, 10);
        run_phase(fwlim_pkg::COUNT_W'($urandom_range(1, 10)),
                  fwlim_pkg::TIME_W'($urandom_range(1, 200)), 230, 18);

        // closing stretch runs at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_phase(fwlim_pkg::COUNT_W'(2), fwlim_pkg::TIME_W'(30), 100, 16);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
